@@ hdl/bfba_pkg.sv @@
// ----------------------------------------------------------------------------
// Best-fit bin assigner package
// Shared sizes, codes and helper functions of the best-fit bin assigner.
// ----------------------------------------------------------------------------
`default_nettype none

package bfba_pkg;

  localparam int CAP_MAX        = 4096;
  localparam int MAX_CONTAINERS = 1024;
  localparam int MAX_SLOTS      = 8;

  localparam int CAP_W   = 13;
  localparam int RIDX_W  = $clog2(CAP_MAX);
  localparam int PWORD_W = 64;
  localparam int PBIT_W  = $clog2(PWORD_W);
  localparam int PIDX_W  = RIDX_W - PBIT_W;
  localparam int PWORDS  = CAP_MAX / PWORD_W;
  localparam int CONT_W  = $clog2(MAX_CONTAINERS);
  localparam int OPEN_W  = CONT_W + 1;
  localparam int SLOT_W  = $clog2(MAX_SLOTS);
  localparam int BPG_W   = 4;
  localparam int TAG_W   = 20;
  localparam int GROUP_W = 10;
  localparam int OSLOT_W = 3;
  localparam int LINK_W  = CONT_W + 1;
  localparam int ROW_W   = CAP_W * MAX_SLOTS;

  localparam logic [1:0] REG_CAP  = 2'd0;
  localparam logic [1:0] REG_BPG  = 2'd1;
  localparam logic [1:0] REG_MODE = 2'd2;

  typedef enum logic [1:0] {
    STAT_PLACED = 2'd0,
    STAT_OPENED = 2'd1,
    STAT_BAD    = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CHECK, S_WORD1, S_WORD2, S_POP, S_POP2,
    S_PLACE, S_BEST, S_PUSH, S_FIN
  } state_t;

  typedef logic [MAX_SLOTS-1:0][CAP_W-1:0] row_t;

  function automatic logic [PBIT_W-1:0] first_set(input logic [PWORD_W-1:0] v);
    logic [PBIT_W-1:0] idx;
    idx = '0;
    for (int i = PWORD_W - 1; i >= 0; i--) begin
      if (v[i]) idx = PBIT_W'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

@@ hdl/bfba_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/bfba_div.sv @@
// ----------------------------------------------------------------------------
// Label divider
// Restoring divider that splits a bin number into group and slot, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bfba_div import bfba_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              go,
  input  wire logic [CONT_W-1:0] num,
  input  wire logic [BPG_W-1:0]  den,
  output logic                   busy,
  output logic [CONT_W-1:0]      quot,
  output logic [BPG_W-1:0]       rem
);

  localparam int CNT_W = $clog2(CONT_W + 1);

  logic [CNT_W-1:0] count;
  logic [BPG_W:0]   trial;

  assign trial = {rem, quot[CONT_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (go) begin
      busy  <= 1'b1;
      count <= CNT_W'(CONT_W);
      quot  <= num;
      rem   <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        rem <= BPG_W'(trial - {1'b0, den});
        quot <= {quot[CONT_W-2:0], 1'b1};
      end else begin
        rem <= trial[BPG_W-1:0];
        quot <= {quot[CONT_W-2:0], 1'b0};
      end
      count <= count - CNT_W'(1);
      if (count == CNT_W'(1)) busy <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ hdl/best_fit_bin_assigner.sv @@
// ----------------------------------------------------------------------------
// Best-fit bin assigner
// Places items by best fit using a room presence bitmap, per-room container
// stacks and a row of bin rooms per container, all held in memories.
// ----------------------------------------------------------------------------
// A bad size is rejected in the check state and a full store after the first
// presence word; in plain mode a placement waits for the 10-step label
// divider, and start_set first passes through the init state. Busy falls in
// the cycle of the result strobe. Reset keeps busy high to open container 0.
// The receiver cannot stall; each result shows on done for one cycle.
`default_nettype none

module best_fit_bin_assigner import bfba_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               start_set,
  input  wire logic [CAP_W-1:0]   item_size,
  input  wire logic [TAG_W-1:0]   item_tag,
  input  wire logic               wr_en,
  input  wire logic [1:0]         wr_index,
  input  wire logic [CAP_W-1:0]   wr_data,
  output logic                    done,
  output logic [TAG_W-1:0]        item_tag_out,
  output logic [GROUP_W-1:0]      group_number,
  output logic [OSLOT_W-1:0]      slot_number,
  output logic [CAP_W-1:0]        space_left,
  output logic [1:0]              status
);

  state_t state, state_next;

  logic [CAP_W-1:0]   reg_cap, cur_cap;
  logic [BPG_W-1:0]   reg_bpg, cur_bpg;
  logic               reg_mode, cur_mode;
  logic               pending;
  logic [CAP_W-1:0]   size;
  logic [TAG_W-1:0]   tag;
  logic [PWORD_W-1:0] summary, pword;
  logic [PIDX_W-1:0]  pw_idx;
  logic [RIDX_W-1:0]  room_idx, best_idx;
  logic [OPEN_W-1:0]  open_count;
  logic [CONT_W-1:0]  cont;
  logic               opened;
  row_t               row;
  logic [SLOT_W-1:0]  slot;
  logic [CAP_W-1:0]   left;

  logic [RIDX_W-1:0]  size_m1, cap_m1, best_m1;
  logic [CAP_W-1:0]   cap_clamp;
  logic [BPG_W-1:0]   bpg_clamp;
  logic [PWORD_W-1:0] word1, masked1, upper1, word_set, word_clr;
  logic [SLOT_W-1:0]  slot_sel;
  logic [CAP_W-1:0]   new_room, best;
  row_t               row_upd;
  logic               present;

  logic               pres_we, head_we, link_we, row_we;
  logic [PIDX_W-1:0]  pres_waddr, pres_raddr;
  logic [PWORD_W-1:0] pres_wdata, pres_rdata;
  logic [RIDX_W-1:0]  head_waddr, head_raddr;
  logic [CONT_W-1:0]  head_wdata, head_rdata;
  logic [CONT_W-1:0]  link_waddr, link_raddr, row_waddr, row_raddr;
  logic [LINK_W-1:0]  link_wdata, link_rdata;
  row_t               row_wdata, row_rdata;

  logic               div_go, div_busy;
  logic [CONT_W-1:0]  div_num, div_quot;
  logic [BPG_W-1:0]   div_rem;

  logic               emit;
  status_t            emit_status;
  logic [GROUP_W-1:0] emit_group;
  logic [OSLOT_W-1:0] emit_slot;
  logic [CAP_W-1:0]   emit_left;

  bfba_ram #(.WIDTH(PWORD_W), .DEPTH(PWORDS)) u_pres (
    .clk(clk), .we(pres_we), .waddr(pres_waddr), .wdata(pres_wdata),
    .raddr(pres_raddr), .rdata(pres_rdata)
  );

  bfba_ram #(.WIDTH(CONT_W), .DEPTH(CAP_MAX)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rdata)
  );

  bfba_ram #(.WIDTH(LINK_W), .DEPTH(MAX_CONTAINERS)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rdata)
  );

  bfba_ram #(.WIDTH(ROW_W), .DEPTH(MAX_CONTAINERS)) u_row (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .raddr(row_raddr), .rdata(row_rdata)
  );

  bfba_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .num(div_num), .den(cur_bpg),
    .busy(div_busy), .quot(div_quot), .rem(div_rem)
  );

  assign cap_clamp = (reg_cap == '0) ? CAP_W'(1) :
                     (reg_cap > CAP_W'(CAP_MAX)) ? CAP_W'(CAP_MAX) : reg_cap;
  assign bpg_clamp = (reg_bpg == '0) ? BPG_W'(1) :
                     (reg_bpg > BPG_W'(MAX_SLOTS)) ? BPG_W'(MAX_SLOTS) : reg_bpg;

  assign size_m1 = RIDX_W'(size - CAP_W'(1));
  assign cap_m1  = RIDX_W'(cur_cap - CAP_W'(1));
  assign best_m1 = RIDX_W'(best - CAP_W'(1));

  assign word1   = summary[size_m1[RIDX_W-1:PBIT_W]] ? pres_rdata : '0;
  assign masked1 = word1 & ({PWORD_W{1'b1}} << size_m1[PBIT_W-1:0]);
  assign upper1  = summary &
                   ~((PWORD_W'(2) << size_m1[RIDX_W-1:PBIT_W]) - PWORD_W'(1));

  assign word_clr = pword & ~(PWORD_W'(1) << room_idx[PBIT_W-1:0]);
  assign word_set = (summary[best_idx[RIDX_W-1:PBIT_W]] ? pres_rdata : '0) |
                    (PWORD_W'(1) << best_idx[PBIT_W-1:0]);
  assign present  = summary[best_idx[RIDX_W-1:PBIT_W]] &
                    pres_rdata[best_idx[PBIT_W-1:0]];

  always_comb begin
    slot_sel = '0;
    if (!cur_mode) begin
      for (int s = 1; s < MAX_SLOTS; s++) begin
        if (BPG_W'(s) < cur_bpg && row[s] >= row[slot_sel]) slot_sel = SLOT_W'(s);
      end
    end
    new_room = row[slot_sel] - size;
    row_upd = row;
    row_upd[slot_sel] = new_room;
  end

  always_comb begin
    best = row[0];
    if (!cur_mode) begin
      for (int s = 1; s < MAX_SLOTS; s++) begin
        if (BPG_W'(s) < cur_bpg && row[s] > best) best = row[s];
      end
    end
  end

  always_comb begin
    state_next  = state;
    pres_we     = 1'b0;
    pres_waddr  = '0;
    pres_wdata  = '0;
    pres_raddr  = '0;
    head_we     = 1'b0;
    head_waddr  = '0;
    head_wdata  = '0;
    head_raddr  = '0;
    link_we     = 1'b0;
    link_waddr  = '0;
    link_wdata  = '0;
    link_raddr  = '0;
    row_we      = 1'b0;
    row_waddr   = '0;
    row_wdata   = row_upd;
    row_raddr   = '0;
    div_go      = 1'b0;
    div_num     = cont;
    emit        = 1'b0;
    emit_status = STAT_PLACED;
    emit_group  = '0;
    emit_slot   = '0;
    emit_left   = '0;
    unique case (state)
      S_INIT: begin
        pres_we    = 1'b1;
        pres_waddr = cap_m1[RIDX_W-1:PBIT_W];
        pres_wdata = PWORD_W'(1) << cap_m1[PBIT_W-1:0];
        head_we    = 1'b1;
        head_waddr = cap_m1;
        link_we    = 1'b1;
        row_we     = 1'b1;
        row_wdata  = {MAX_SLOTS{cur_cap}};
        state_next = pending ? S_CHECK : S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = start_set ? S_INIT : S_CHECK;
      end
      S_CHECK: begin
        pres_raddr = size_m1[RIDX_W-1:PBIT_W];
        if (size == '0 || size > cur_cap) begin
          emit        = 1'b1;
          emit_status = STAT_BAD;
          state_next  = S_IDLE;
        end else begin
          state_next = S_WORD1;
        end
      end
      S_WORD1: begin
        if (masked1 != '0) begin
          head_raddr = {size_m1[RIDX_W-1:PBIT_W], first_set(masked1)};
          state_next = S_POP;
        end else if (upper1 != '0) begin
          pres_raddr = first_set(upper1);
          state_next = S_WORD2;
        end else if (open_count >= OPEN_W'(MAX_CONTAINERS)) begin
          emit        = 1'b1;
          emit_status = STAT_FULL;
          state_next  = S_IDLE;
        end else begin
          div_go     = 1'b1;
          div_num    = open_count[CONT_W-1:0];
          state_next = S_PLACE;
        end
      end
      S_WORD2: begin
        head_raddr = {pw_idx, first_set(pres_rdata)};
        state_next = S_POP;
      end
      S_POP: begin
        link_raddr = head_rdata;
        row_raddr  = head_rdata;
        div_go     = 1'b1;
        div_num    = head_rdata;
        state_next = S_POP2;
      end
      S_POP2: begin
        if (link_rdata[CONT_W]) begin
          head_we    = 1'b1;
          head_waddr = room_idx;
          head_wdata = link_rdata[CONT_W-1:0];
        end else begin
          pres_we    = 1'b1;
          pres_waddr = room_idx[RIDX_W-1:PBIT_W];
          pres_wdata = word_clr;
        end
        state_next = S_PLACE;
      end
      S_PLACE: begin
        row_we     = 1'b1;
        row_waddr  = cont;
        state_next = S_BEST;
      end
      S_BEST: begin
        pres_raddr = best_m1[RIDX_W-1:PBIT_W];
        head_raddr = best_m1;
        state_next = (best == '0) ? S_FIN : S_PUSH;
      end
      S_PUSH: begin
        link_we    = 1'b1;
        link_waddr = cont;
        link_wdata = {present, head_rdata};
        head_we    = 1'b1;
        head_waddr = best_idx;
        head_wdata = cont;
        pres_we    = 1'b1;
        pres_waddr = best_idx[RIDX_W-1:PBIT_W];
        pres_wdata = word_set;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!cur_mode || !div_busy) begin
          emit        = 1'b1;
          emit_status = opened ? STAT_OPENED : STAT_PLACED;
          emit_group  = cur_mode ? GROUP_W'(div_quot) : GROUP_W'(cont);
          emit_slot   = cur_mode ? OSLOT_W'(div_rem) : OSLOT_W'(slot);
          emit_left   = left;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_cap    <= CAP_W'(CAP_MAX);
      reg_bpg    <= BPG_W'(1);
      reg_mode   <= 1'b0;
      cur_cap    <= CAP_W'(CAP_MAX);
      cur_bpg    <= BPG_W'(1);
      cur_mode   <= 1'b0;
      pending    <= 1'b0;
      summary    <= '0;
      open_count <= OPEN_W'(1);
      done       <= 1'b0;
    end else begin
      done <= emit;
      if (wr_en) begin
        unique case (wr_index)
          REG_CAP:  reg_cap  <= wr_data;
          REG_BPG:  reg_bpg  <= wr_data[BPG_W-1:0];
          REG_MODE: reg_mode <= wr_data[0];
          default:  ;
        endcase
      end
      unique case (state)
        S_INIT: begin
          summary    <= PWORD_W'(1) << cap_m1[RIDX_W-1:PBIT_W];
          open_count <= OPEN_W'(1);
          pending    <= 1'b0;
        end
        S_IDLE: begin
          if (start && start_set) begin
            cur_cap  <= cap_clamp;
            cur_bpg  <= bpg_clamp;
            cur_mode <= reg_mode;
            pending  <= 1'b1;
          end
        end
        S_WORD1: begin
          if (masked1 == '0 && upper1 == '0 &&
              open_count < OPEN_W'(MAX_CONTAINERS)) begin
            open_count <= open_count + OPEN_W'(1);
          end
        end
        S_POP2: begin
          if (!link_rdata[CONT_W] && word_clr == '0) begin
            summary[room_idx[RIDX_W-1:PBIT_W]] <= 1'b0;
          end
        end
        S_PUSH: summary[best_idx[RIDX_W-1:PBIT_W]] <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      size <= item_size;
      tag  <= item_tag;
    end
    unique case (state)
      S_WORD1: begin
        pword    <= word1;
        room_idx <= {size_m1[RIDX_W-1:PBIT_W], first_set(masked1)};
        pw_idx   <= first_set(upper1);
        cont     <= open_count[CONT_W-1:0];
        opened   <= 1'b1;
        row      <= {MAX_SLOTS{cur_cap}};
      end
      S_WORD2: begin
        pword    <= pres_rdata;
        room_idx <= {pw_idx, first_set(pres_rdata)};
      end
      S_POP: begin
        cont   <= head_rdata;
        opened <= 1'b0;
      end
      S_POP2: row <= row_rdata;
      S_PLACE: begin
        row  <= row_upd;
        slot <= slot_sel;
        left <= new_room;
      end
      S_BEST: best_idx <= best_m1;
      default: ;
    endcase
    if (emit) begin
      item_tag_out <= tag;
      group_number <= emit_group;
      slot_number  <= emit_slot;
      space_left   <= emit_left;
      status       <= emit_status;
    end
  end

  assign busy = (state != S_IDLE);

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without an item in work");

  a_open_range: assert property (@(posedge clk) disable iff (rst)
    open_count >= OPEN_W'(1) && open_count <= OPEN_W'(MAX_CONTAINERS))
    else $error("open container count out of range");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status == STAT_BAD || status == STAT_FULL) |->
      group_number == '0 && slot_number == '0 && space_left == '0)
    else $error("rejected item carries a placement");

  a_summary_set: assert property (@(posedge clk) disable iff (rst)
    state == S_PUSH |=> summary[$past(best_idx[RIDX_W-1:PBIT_W])])
    else $error("pushed room not marked in summary");

endmodule

`default_nettype wire
